// ----- src/cnlc_pkg.sv -----
// ----------------------------------------------------------------------------
// cnlc_pkg: shared types and constants of the card number classifier
// Class codes, issuer rule constants and the command/status structs that
// join the controller to the datapath.
// ----------------------------------------------------------------------------
package cnlc_pkg;

   localparam int NUMBER_BITS_DEFAULT = 63;
   localparam int DIGIT_COUNT_W       = 5;
   localparam int CLASS_W             = 2;

   typedef enum logic [CLASS_W-1:0] {
      CLASS_INVALID    = 2'd0,
      CLASS_AMEX       = 2'd1,
      CLASS_VISA       = 2'd2,
      CLASS_MASTERCARD = 2'd3
   } card_class_type;

   // Issuer rules, as lengths and leading digits.
   localparam logic [DIGIT_COUNT_W-1:0] LEN_AMEX       = 5'd15;
   localparam logic [DIGIT_COUNT_W-1:0] LEN_VISA_SHORT = 5'd13;
   localparam logic [DIGIT_COUNT_W-1:0] LEN_LONG       = 5'd16;
   localparam logic [3:0] AMEX_FIRST      = 4'd3;
   localparam logic [3:0] AMEX_SECOND_A   = 4'd4;
   localparam logic [3:0] AMEX_SECOND_B   = 4'd7;
   localparam logic [3:0] VISA_FIRST      = 4'd4;
   localparam logic [3:0] MC_FIRST        = 4'd5;
   localparam logic [3:0] MC_SECOND_LOW   = 4'd1;
   localparam logic [3:0] MC_SECOND_HIGH  = 4'd5;

   typedef struct packed {
      logic load;      // capture a new number and clear the conversion and scan state
      logic convert;   // one binary-to-BCD shift step
      logic scan;      // one digit of the Luhn scan
      logic out_load;  // load the result register
   } dp_cmd_type;

   typedef struct packed {
      logic convert_last;  // the current convert step is the final one
      logic scan_last;     // the current scan step is the final one
   } dp_status_type;

endpackage

// ----- src/cnlc_datapath.sv -----
// ----------------------------------------------------------------------------
// cnlc_datapath: conversion and Luhn scan datapath
// Shift-and-add-3 binary to BCD conversion, then a digit-serial scan that
// forms the Luhn sum modulo ten, the digit count and the two leading digits.
// ----------------------------------------------------------------------------
module cnlc_datapath
   import cnlc_pkg::*;
#(
   parameter int NUMBER_BITS = NUMBER_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  dp_cmd_type               cmd,
   output dp_status_type            status,
   input  logic [NUMBER_BITS-1:0]   req_card_number,
   output logic [CLASS_W-1:0]       rsp_card_class,
   output logic                     rsp_luhn_ok,
   output logic [DIGIT_COUNT_W-1:0] rsp_digit_count
);

   // Decimal digits needed for NUMBER_BITS bits: floor(bits * log10(2)) + 1.
   localparam int BCD_DIGITS = (NUMBER_BITS * 30103) / 100000 + 1;
   localparam int BCD_W      = 4 * BCD_DIGITS;
   localparam int BIT_CNT_W  = $clog2(NUMBER_BITS);
   localparam int IDX_W      = $clog2(BCD_DIGITS);

   logic [NUMBER_BITS-1:0]   bin_ff, bin_in;
   logic [BCD_W-1:0]         bcd_ff, bcd_in;
   logic [BCD_W-1:0]         bcd_adj;
   logic [BIT_CNT_W-1:0]     bit_cnt_ff, bit_cnt_in;
   logic [IDX_W-1:0]         idx_ff, idx_in;
   logic [DIGIT_COUNT_W-1:0] count_ff, count_in;
   logic [3:0]               lead_hi_ff, lead_hi_in;
   logic [3:0]               lead_lo_ff, lead_lo_in;
   logic [3:0]               prev_ff, prev_in;
   logic [3:0]               luhn_ff, luhn_in;
   logic [CLASS_W-1:0]       class_ff, class_in;
   logic                     ok_ff, ok_in;
   logic [DIGIT_COUNT_W-1:0] out_count_ff, out_count_in;

   logic [3:0] cur_digit;
   logic [4:0] twice;
   logic [4:0] contrib;
   logic [4:0] sum;
   logic       luhn_ok;
   card_class_type cls;

   assign status.convert_last = (bit_cnt_ff == BIT_CNT_W'(NUMBER_BITS - 1));
   assign status.scan_last    = (idx_ff == IDX_W'(BCD_DIGITS - 1));

   // Add 3 to every BCD digit of five or more before the shift.
   always_comb begin
      logic [3:0] digit;
      for (int i = 0; i < BCD_DIGITS; i++) begin
         digit = bcd_ff[4*i +: 4];
         bcd_adj[4*i +: 4] = (digit >= 4'd5) ? digit + 4'd3 : digit;
      end
   end

   // Luhn contribution of the digit at the bottom of the BCD word.
   assign cur_digit = bcd_ff[3:0];
   assign twice     = {cur_digit, 1'b0};
   always_comb begin
      if (idx_ff[0]) begin
         contrib = (twice > 5'd9) ? twice - 5'd9 : twice;
      end else begin
         contrib = {1'b0, cur_digit};
      end
      sum = {1'b0, luhn_ff} + contrib;
   end

   // Issuer rules on the finished scan.
   assign luhn_ok = (count_ff != '0) && (luhn_ff == 4'd0);
   always_comb begin
      cls = CLASS_INVALID;
      if (luhn_ok) begin
         if (count_ff == LEN_AMEX && lead_hi_ff == AMEX_FIRST &&
             (lead_lo_ff == AMEX_SECOND_A || lead_lo_ff == AMEX_SECOND_B)) begin
            cls = CLASS_AMEX;
         end else if (lead_hi_ff == VISA_FIRST &&
                      (count_ff == LEN_VISA_SHORT || count_ff == LEN_LONG)) begin
            cls = CLASS_VISA;
         end else if (count_ff == LEN_LONG && lead_hi_ff == MC_FIRST &&
                      lead_lo_ff >= MC_SECOND_LOW && lead_lo_ff <= MC_SECOND_HIGH) begin
            cls = CLASS_MASTERCARD;
         end
      end
   end

   always_comb begin
      bin_in       = bin_ff;
      bcd_in       = bcd_ff;
      bit_cnt_in   = bit_cnt_ff;
      idx_in       = idx_ff;
      count_in     = count_ff;
      lead_hi_in   = lead_hi_ff;
      lead_lo_in   = lead_lo_ff;
      prev_in      = prev_ff;
      luhn_in      = luhn_ff;
      class_in     = class_ff;
      ok_in        = ok_ff;
      out_count_in = out_count_ff;
      if (cmd.load) begin
         bin_in     = req_card_number;
         bcd_in     = '0;
         bit_cnt_in = '0;
         idx_in     = '0;
         count_in   = '0;
         lead_hi_in = '0;
         lead_lo_in = '0;
         prev_in    = '0;
         luhn_in    = '0;
      end
      if (cmd.convert) begin
         bcd_in     = {bcd_adj[BCD_W-2:0], bin_ff[NUMBER_BITS-1]};
         bin_in     = {bin_ff[NUMBER_BITS-2:0], 1'b0};
         bit_cnt_in = bit_cnt_ff + BIT_CNT_W'(1);
      end
      if (cmd.scan) begin
         luhn_in = (sum >= 5'd10) ? 4'(sum - 5'd10) : sum[3:0];
         if (cur_digit != 4'd0) begin
            count_in   = DIGIT_COUNT_W'(idx_ff) + DIGIT_COUNT_W'(1);
            lead_hi_in = cur_digit;
            lead_lo_in = prev_ff;
         end
         prev_in = cur_digit;
         bcd_in  = {4'd0, bcd_ff[BCD_W-1:4]};
         idx_in  = idx_ff + IDX_W'(1);
      end
      if (cmd.out_load) begin
         class_in     = cls;
         ok_in        = luhn_ok;
         out_count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_cnt_ff <= '0;
         idx_ff     <= '0;
      end else begin
         bit_cnt_ff <= bit_cnt_in;
         idx_ff     <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff       <= bin_in;
      bcd_ff       <= bcd_in;
      count_ff     <= count_in;
      lead_hi_ff   <= lead_hi_in;
      lead_lo_ff   <= lead_lo_in;
      prev_ff      <= prev_in;
      luhn_ff      <= luhn_in;
      class_ff     <= class_in;
      ok_ff        <= ok_in;
      out_count_ff <= out_count_in;
   end

   assign rsp_card_class  = class_ff;
   assign rsp_luhn_ok     = ok_ff;
   assign rsp_digit_count = out_count_ff;

endmodule

// ----- src/cnlc_ctrl.sv -----
// ----------------------------------------------------------------------------
// cnlc_ctrl: sequencing controller of the card number classifier
// Steps the datapath through capture, conversion and scan, and owns the
// handshakes of both channels.
// ----------------------------------------------------------------------------
module cnlc_ctrl
   import cnlc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output dp_cmd_type    cmd,
   input  dp_status_type status
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SCAN,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            cmd.convert = 1'b1;
            if (status.convert_last) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // A waiting result is never overwritten.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !cmd.out_load)
      else $error("result register loaded while a beat is still waiting");

   // An accepted beat starts the conversion in the next cycle.
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_CONVERT))
      else $error("accepted beat did not start the conversion");

   // The final conversion step hands over to the scan.
   a_convert_to_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CONVERT && status.convert_last) |=> (state_ff == ST_SCAN))
      else $error("conversion did not hand over to the scan");

   // Every result load raises the output valid.
   a_load_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_valid_ff)
      else $error("result loaded without raising valid");

endmodule

// ----- src/card_number_luhn_classifier_top.sv -----
// ----------------------------------------------------------------------------
// card_number_luhn_classifier_top: Luhn mod-10 card number classifier
// Classifies a binary card number as invalid, amex, visa or mastercard.
// ----------------------------------------------------------------------------
// One beat on the req_ channel carries a card number as an unsigned binary
// integer; one beat on the rsp_ channel returns its class, the Luhn check
// flag and the count of decimal digits. A number is worked in two steps: the
// shift-and-add-3 converter takes one bit of the number per cycle, and the
// scan then walks the BCD word (19 digits at the default of 63 bits) one
// digit per cycle to form the Luhn sum modulo ten, the length and the two
// leading digits. One number is in work at a time; req_stall is low only
// while the block is idle. A finished result sits in an output register, so
// the next number is accepted while the previous result still waits to be
// taken; a finished number waits in its last state until that register is
// free. Zero reports zero digits and invalid. Lengths other than 13, 15 and
// 16 always classify as invalid, while luhn_ok and digit_count are still
// reported for them.
// ----------------------------------------------------------------------------
module card_number_luhn_classifier_top
   import cnlc_pkg::*;
#(
   parameter int NUMBER_BITS = NUMBER_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [NUMBER_BITS-1:0]   req_card_number,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [CLASS_W-1:0]       rsp_card_class,
   output logic                     rsp_luhn_ok,
   output logic [DIGIT_COUNT_W-1:0] rsp_digit_count
);

   // Commands flow from the controller to the datapath, status flows back.
   dp_cmd_type    cmd;
   dp_status_type status;

   cnlc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   // The datapath holds the number, the BCD word, the scan results and
   // the output register.
   cnlc_datapath #(
      .NUMBER_BITS (NUMBER_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_card_number (req_card_number),
      .rsp_card_class  (rsp_card_class),
      .rsp_luhn_ok     (rsp_luhn_ok),
      .rsp_digit_count (rsp_digit_count)
   );

endmodule

// ----- sim/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the Luhn card number classifier
// Drives binary card numbers into the req_ channel and checks every rsp_ beat
// against a behavioral classifier or a directed row, under several idling patterns.
// ----------------------------------------------------------------------------
module tb_top;
   import cnlc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUMBER_BITS      = NUMBER_BITS_DEFAULT;
   localparam int RANDOM_PER_PHASE = 450;
   // The drain is long enough to catch any stray result once the last
   // expected one has come back.
   localparam int DRAIN_CYCLES     = 200;
   // The limit is far beyond the slowest correct run.
   localparam int CYCLE_LIMIT      = 1_500_000;

   typedef logic [NUMBER_BITS-1:0] card_number_type;

   typedef struct packed {
      card_class_type           card_class;
      logic                     luhn_ok;
      logic [DIGIT_COUNT_W-1:0] digit_count;
   } card_result_type;

   // One entry per accepted number, oldest first.
   typedef struct {
      card_number_type number;
      card_result_type result;
   } pending_card_type;

   // A row of the directed table. Where typed is set, the expected result
   // is taken from the row instead of from the classifier below.
   typedef struct {
      card_number_type number;
      bit              typed;
      card_result_type result;
   } directed_row_type;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   card_number_type          req_card_number;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [CLASS_W-1:0]       rsp_card_class;
   logic                     rsp_luhn_ok;
   logic [DIGIT_COUNT_W-1:0] rsp_digit_count;

   // Side band that travels with the req_ beat: the typed-in expectation
   // of a directed row, if it has one.
   bit                       row_typed;
   card_result_type          row_result;

   pending_card_type         pending_cards[$];
   pending_card_type         oldest_card;
   directed_row_type         directed_rows[$];

   int                       send_idle_pct;
   int                       recv_stall_pct;
   int                       phase_send_idle[4]  = '{0, 88, 0, 11};
   int                       phase_recv_stall[4] = '{0, 0, 88, 11};

   int                       accepted_count;
   int                       checked_count;
   int                       mismatch_count;
   int                       class_tally[4];
   int                       cycle_count;

   card_number_luhn_classifier_top #(
      .NUMBER_BITS(NUMBER_BITS)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_card_number(req_card_number),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_card_class (rsp_card_class),
      .rsp_luhn_ok    (rsp_luhn_ok),
      .rsp_digit_count(rsp_digit_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Behavioral classifier. The number is peeled one decimal digit at a
   // time from the right; digits at even positions are doubled and folded
   // back to a single digit before they join the Luhn sum. The two leading
   // digits are whatever remains when the number has shrunk to two digits.
   function automatic card_result_type classify_card(card_number_type number);
      longint unsigned rest;
      int unsigned     digits;
      int unsigned     luhn_sum;
      int unsigned     lead;
      int unsigned     digit;
      int unsigned     twice;
      bit              sum_ok;
      card_result_type result;
      rest     = 64'(number);
      digits   = 0;
      luhn_sum = 0;
      lead     = 0;
      while (rest != 0) begin
         digit = 32'(rest % 10);
         digits++;
         if (digits % 2 == 0) begin
            twice = digit * 2;
            luhn_sum += (twice > 9) ? twice - 9 : twice;
         end else begin
            luhn_sum += digit;
         end
         if (rest >= 10 && rest <= 99) begin
            lead = 32'(rest);
         end
         rest = rest / 10;
      end
      sum_ok = (digits > 0) && (luhn_sum % 10 == 0);
      result.card_class  = CLASS_INVALID;
      result.luhn_ok     = sum_ok;
      result.digit_count = DIGIT_COUNT_W'(digits);
      // Issuers only count when the sum passes and the length is one that
      // some issuer uses; a 14-digit number never classifies.
      if (sum_ok && (digits == LEN_VISA_SHORT || digits == LEN_AMEX ||
                     digits == LEN_LONG)) begin
         if (digits == LEN_AMEX && (lead == 34 || lead == 37)) begin
            result.card_class = CLASS_AMEX;
         end else if (lead / 10 == 4 && (digits == LEN_VISA_SHORT || digits == LEN_LONG)) begin
            result.card_class = CLASS_VISA;
         end else if (lead > 50 && lead < 56 && digits == LEN_LONG) begin
            result.card_class = CLASS_MASTERCARD;
         end
      end
      return result;
   endfunction

   // Random card numbers. Most look like real cards of one issuer, with the
   // check digit usually chosen to complete the Luhn sum, so that every
   // class comes up often. The rest are near misses with a random prefix and
   // length, numbers of any length up to 19 digits, and raw 63-bit values
   // that toggle every bit of the port.
   function automatic card_number_type make_card_number();
      int unsigned     pick;
      int unsigned     len;
      int unsigned     prefix;
      int unsigned     i;
      longint unsigned number;
      card_result_type trial;
      pick = $urandom_range(99);
      if (pick < 70) begin
         if (pick < 55) begin
            case ($urandom_range(2))
               0: begin
                  len    = 15;
                  prefix = $urandom_range(1) ? 34 : 37;
               end
               1: begin
                  len    = $urandom_range(1) ? 13 : 16;
                  prefix = 40 + $urandom_range(9);
               end
               default: begin
                  len    = 16;
                  prefix = 51 + $urandom_range(4);
               end
            endcase
         end else begin
            len    = $urandom_range(17, 12);
            prefix = $urandom_range(99, 10);
         end
         // Two prefix digits and len - 3 random ones, then the check digit.
         number = 64'(prefix);
         for (i = 0; i < len - 3; i++) begin
            number = number * 10 + $urandom_range(9);
         end
         number = number * 10;
         if ($urandom_range(99) < 85) begin
            // If none of 0 to 8 completes the sum, 9 does.
            for (i = 0; i < 9; i++) begin
               trial = classify_card(card_number_type'(number + i));
               if (trial.luhn_ok) begin
                  break;
               end
            end
            number = number + i;
         end else begin
            number = number + $urandom_range(9);
         end
      end else if (pick < 85) begin
         len = $urandom_range(19, 1);
         // A 19-digit number must stay below 2**63, so it leads with 1 to 8.
         if (len == 1) begin
            number = 64'($urandom_range(9));
         end else if (len == 19) begin
            number = 64'($urandom_range(8, 1));
         end else begin
            number = 64'($urandom_range(9, 1));
         end
         for (i = 1; i < len; i++) begin
            number = number * 10 + $urandom_range(9);
         end
      end else begin
         number = {$urandom, $urandom};
         if ($urandom_range(3) == 0) begin
            number = number & {$urandom, $urandom};
         end
      end
      return card_number_type'(number);
   endfunction

   task automatic add_row(input card_number_type number, input bit typed,
                          input card_class_type card_class, input logic luhn_ok,
                          input logic [DIGIT_COUNT_W-1:0] digit_count);
      directed_row_type row;
      row.number             = number;
      row.typed              = typed;
      row.result.card_class  = card_class;
      row.result.luhn_ok     = luhn_ok;
      row.result.digit_count = digit_count;
      directed_rows.push_back(row);
   endtask

   // Offers one number on the req_ channel. It is entered at a falling edge
   // and returns at the falling edge after the beat was taken. Valid stays
   // high straight into the next beat when no idle cycle is drawn.
   task automatic offer_card_number(input card_number_type number, input bit typed,
                                    input card_result_type typed_result);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_card_number <= number;
      row_typed       <= typed;
      row_result      <= typed_result;
      do begin
         @(posedge clock);
      end while (req_stall);
      @(negedge clock);
   endtask

   // The receiver draws a fresh stall every cycle, at the falling edge.
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // Scoreboard. Both channels are sampled at the rising edge. An accepted
   // req_ beat queues its expected result; an accepted rsp_ beat is checked
   // against the oldest one in the queue, field by field.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            oldest_card.number = req_card_number;
            oldest_card.result = row_typed ? row_result : classify_card(req_card_number);
            pending_cards.push_back(oldest_card);
            accepted_count++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_cards.size() == 0) begin
               if (mismatch_count < 10) begin
                  $display("Unexpected result beat: class %0d luhn %0d digits %0d",
                           rsp_card_class, rsp_luhn_ok, rsp_digit_count);
               end
               mismatch_count++;
            end else begin
               oldest_card = pending_cards.pop_front();
               checked_count++;
               class_tally[int'(oldest_card.result.card_class)]++;
               if (rsp_card_class !== oldest_card.result.card_class ||
                   rsp_luhn_ok !== oldest_card.result.luhn_ok ||
                   rsp_digit_count !== oldest_card.result.digit_count) begin
                  if (mismatch_count < 10) begin
                     $write("Mismatch on %0d: expected class %0d luhn %0d digits %0d, ",
                            oldest_card.number, oldest_card.result.card_class,
                            oldest_card.result.luhn_ok, oldest_card.result.digit_count);
                     $display("got class %0d luhn %0d digits %0d",
                              rsp_card_class, rsp_luhn_ok, rsp_digit_count);
                  end
                  mismatch_count++;
               end
            end
         end
      end
   end

   // Watchdog: a hung handshake or a lost result ends the run here.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, pending_cards.size());
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      req_valid       = 1'b0;
      req_card_number = '0;
      row_typed       = 1'b0;
      row_result      = '0;
      reset           = 1'b1;
      send_idle_pct   = 0;
      recv_stall_pct  = 0;
      accepted_count  = 0;
      checked_count   = 0;
      mismatch_count  = 0;
      foreach (class_tally[i]) begin
         class_tally[i] = 0;
      end

      // Directed table. Zero and the short numbers, the well-known issuer
      // test numbers, prefixes just outside the mastercard range, issuer
      // prefixes at the wrong length, a 14-digit number that passes the sum,
      // a failing check digit, and the widest values the port can carry.
      add_row(63'd0,                  1, CLASS_INVALID,    1'b0, 5'd0);
      add_row(63'd1,                  1, CLASS_INVALID,    1'b0, 5'd1);
      add_row(63'd9,                  1, CLASS_INVALID,    1'b0, 5'd1);
      add_row(63'd18,                 1, CLASS_INVALID,    1'b1, 5'd2);
      add_row(63'd99,                 0, CLASS_INVALID,    1'b0, 5'd0);
      add_row(63'd378_282_246_310_005, 1, CLASS_AMEX,      1'b1, 5'd15);
      add_row(63'd371_449_635_398_431, 0, CLASS_INVALID,   1'b0, 5'd0);
      add_row(63'd340_000_000_000_009, 1, CLASS_AMEX,      1'b1, 5'd15);
      add_row(63'd370_000_000_000_002, 1, CLASS_AMEX,      1'b1, 5'd15);
      add_row(63'd4111_1111_1111_1111, 1, CLASS_VISA,      1'b1, 5'd16);
      add_row(63'd4_222_222_222_222,   1, CLASS_VISA,      1'b1, 5'd13);
      add_row(63'd4_000_000_000_006,   1, CLASS_VISA,      1'b1, 5'd13);
      add_row(63'd400_000_000_000_006, 1, CLASS_INVALID,   1'b1, 5'd15);
      add_row(63'd4111_1111_1111_1112, 1, CLASS_INVALID,   1'b0, 5'd16);
      add_row(63'd5555_5555_5555_4444, 1, CLASS_MASTERCARD, 1'b1, 5'd16);
      add_row(63'd5105_1051_0510_5100, 0, CLASS_INVALID,   1'b0, 5'd0);
      add_row(63'd5100_0000_0000_0008, 1, CLASS_MASTERCARD, 1'b1, 5'd16);
      add_row(63'd5000_0000_0000_0009, 1, CLASS_INVALID,   1'b1, 5'd16);
      add_row(63'd5600_0000_0000_0003, 1, CLASS_INVALID,   1'b1, 5'd16);
      add_row(63'd3400_0000_0000_0000, 1, CLASS_INVALID,   1'b1, 5'd16);
      add_row(63'd30_569_309_025_904,  1, CLASS_INVALID,   1'b1, 5'd14);
      add_row(63'd1_000_000_000_000_000_000, 1, CLASS_INVALID, 1'b0, 5'd19);
      add_row({NUMBER_BITS{1'b1}},     0, CLASS_INVALID,   1'b0, 5'd0);
      add_row(63'h5555_5555_5555_5555, 0, CLASS_INVALID,   1'b0, 5'd0);
      add_row(63'h2AAA_AAAA_AAAA_AAAA, 0, CLASS_INVALID,   1'b0, 5'd0);
      add_row(63'h4000_0000_0000_0000, 0, CLASS_INVALID,   1'b0, 5'd0);

      // Synchronous reset, released at a falling edge.
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // The directed table runs with no idling on either side.
      foreach (directed_rows[i]) begin
         offer_card_number(directed_rows[i].number, directed_rows[i].typed,
                           directed_rows[i].result);
      end

      // Random part in four phases: no idling, a mostly idle sender, a
      // mostly stalling receiver, and light idling on both sides.
      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct  = phase_send_idle[phase];
         recv_stall_pct = phase_recv_stall[phase];
         repeat (RANDOM_PER_PHASE) begin
            offer_card_number(make_card_number(), 1'b0, '0);
         end
      end
      req_valid <= 1'b0;

      // Drain every outstanding result, then keep watching a while longer
      // so that any surplus beat shows up as unexpected.
      while (pending_cards.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Checked %0d results for %0d card numbers (%0d directed) in four phases.",
               checked_count, accepted_count, directed_rows.size());
      $display("Classes: %0d invalid, %0d amex, %0d visa, %0d mastercard; %0d mismatches.",
               class_tally[0], class_tally[1], class_tally[2], class_tally[3],
               mismatch_count);
      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
